// ----- rtl/bba_pkg.sv -----
// Package for the block bitmap allocator.
// Map geometry, register offsets, command and status codes, sequencer states.
// No dependencies.
package bba_pkg;

	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int NUM_WORDS  = NUM_BLOCKS / WORD_BITS;
	localparam int BIT_IDX_W  = $clog2(WORD_BITS);
	localparam int WORD_IDX_W = $clog2(NUM_WORDS);
	localparam int BLK_W      = 12;
	localparam int CFG_W      = 13;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [CFG_W-1:0] TOTAL_RESET    = CFG_W'(4096);
	localparam logic [CFG_W-1:0] RESERVED_RESET = CFG_W'(1);
	localparam logic [CFG_W-1:0] NUM_BLOCKS_C   = CFG_W'(NUM_BLOCKS);

	typedef logic [WORD_BITS-1:0] word_t;

	// register index taken from paddr[2]
	typedef enum logic {
		REG_TOTAL    = 1'b0,
		REG_RESERVED = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_OUT_OF_BLOCKS = 2'd1;
	localparam logic [1:0] ST_DOUBLE_FREE   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_DONE
	} state_t;

endpackage

// ----- rtl/bba_find_first.sv -----
// Find-first-set over one bitmap word: lowest set bit and a hit flag.
// Uses bba_pkg for the word width.
module bba_find_first (
	input  bba_pkg::word_t                   vec,
	output logic                             found,
	output logic [bba_pkg::BIT_IDX_W-1:0]    idx
);
	import bba_pkg::*;

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				idx   = BIT_IDX_W'(i);
			end
		end
	end

endmodule

// ----- rtl/block_bitmap_allocator.sv -----
// First-fit block allocator over an in-use bitmap held in a 64 x 64-bit memory.
// Allocate: one map word checked per cycle from the first unreserved word; no scan when
// reserved covers every usable block. Free: clears the bit or flags a double free; frees of
// reserved blocks are ignored. Next transfer is taken once the last result enters the
// output register; a stalled result there blocks it. Reset clears all word valid flags
// (map reads as all free), loads total 4096, reserved 1. Uses bba_pkg, bba_find_first.
module block_bitmap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bba_pkg::ADDR_W-1:0]    paddr,
	input  logic [bba_pkg::DATA_W-1:0]    pwdata,
	output logic [bba_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [bba_pkg::BLK_W-1:0]     block_number,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::BLK_W-1:0]     block_number_res,
	output logic [1:0]                    status
);
	import bba_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0] total_q, reserved_q;
	logic [CFG_W-1:0] lim, lim_m1;

	word_t                 mem [NUM_WORDS];
	logic [NUM_WORDS-1:0]  word_valid_q;
	word_t                 rd_data_q;
	logic                  rd_valid_q;
	logic [WORD_IDX_W-1:0] rd_addr;
	logic                  wr_en;
	logic [WORD_IDX_W-1:0] wr_addr;
	word_t                 wr_data;

	logic [WORD_IDX_W-1:0] chk_idx_q, chk_idx_d;
	logic [BLK_W-1:0]      blk_q, blk_d;
	logic [BLK_W-1:0]      res_q, res_d;
	logic [1:0]            st_q, st_d;

	logic                  out_valid_q;
	logic [BLK_W-1:0]      out_res_q;
	logic [1:0]            out_st_q;

	logic                  accept;
	logic                  can_emit;
	word_t                 word;
	word_t                 lo_mask, hi_mask, cand, bit_sel;
	logic                  hit;
	logic [BIT_IDX_W-1:0]  hit_idx;
	logic [WORD_IDX_W-1:0] first_word, last_word;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RESET;
			reserved_q <= RESERVED_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_TOTAL:    total_q    <= pwdata[CFG_W-1:0];
				REG_RESERVED: reserved_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_TOTAL:    prdata = DATA_W'(total_q);
			REG_RESERVED: prdata = DATA_W'(reserved_q);
			default:      prdata = '0;
		endcase
	end

	assign lim        = (total_q > NUM_BLOCKS_C) ? NUM_BLOCKS_C : total_q;
	assign lim_m1     = lim - CFG_W'(1);
	assign first_word = reserved_q[BLK_W-1:BIT_IDX_W];
	assign last_word  = lim_m1[BLK_W-1:BIT_IDX_W];

	// ---------------- map memory ----------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			rd_valid_q <= word_valid_q[rd_addr];
			if (wr_en) begin
				word_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// a word never written reads as all free
	assign word = rd_valid_q ? rd_data_q : '0;

	// ---------------- scan datapath ----------------
	always_comb begin
		lo_mask = '1;
		hi_mask = '1;
		if (chk_idx_q == first_word) begin
			lo_mask = word_t'('1) << reserved_q[BIT_IDX_W-1:0];
		end
		// shift by 63 - bit index of the last usable block
		if (chk_idx_q == last_word) begin
			hi_mask = word_t'('1) >> (~lim_m1[BIT_IDX_W-1:0]);
		end
		cand = ~word & lo_mask & hi_mask;
	end

	bba_find_first u_find (
		.vec   (cand),
		.found (hit),
		.idx   (hit_idx)
	);

	// ---------------- sequencer ----------------
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign can_emit = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_q <= chk_idx_d;
		blk_q     <= blk_d;
		res_q     <= res_d;
		st_q      <= st_d;
	end

	always_comb begin
		state_d   = state_q;
		chk_idx_d = chk_idx_q;
		blk_d     = blk_q;
		res_d     = res_q;
		st_d      = st_q;
		rd_addr   = chk_idx_q;
		wr_en     = 1'b0;
		wr_addr   = chk_idx_q;
		wr_data   = word;
		bit_sel   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_t'(cmd) == CMD_FREE) begin
					rd_addr = block_number[BLK_W-1:BIT_IDX_W];
				end else begin
					rd_addr = first_word;
				end
				if (accept) begin
					res_d = '0;
					st_d  = ST_OK;
					blk_d = block_number;
					if (cmd_t'(cmd) == CMD_FREE) begin
						// reserved blocks stay in use; the free is ignored
						if ({1'b0, block_number} < reserved_q) begin
							state_d = S_DONE;
						end else begin
							state_d = S_FREE_CHK;
						end
					end else if (reserved_q >= lim) begin
						st_d    = ST_OUT_OF_BLOCKS;
						state_d = S_DONE;
					end else begin
						chk_idx_d = first_word;
						state_d   = S_SCAN;
					end
				end
			end

			S_SCAN: begin
				// read ahead one word while the current one is checked
				rd_addr = chk_idx_q + WORD_IDX_W'(1);
				if (hit) begin
					bit_sel = word_t'(1) << hit_idx;
					wr_en   = 1'b1;
					wr_data = word | bit_sel;
					res_d   = {chk_idx_q, hit_idx};
					state_d = S_DONE;
				end else if (chk_idx_q == last_word) begin
					st_d    = ST_OUT_OF_BLOCKS;
					state_d = S_DONE;
				end else begin
					chk_idx_d = chk_idx_q + WORD_IDX_W'(1);
				end
			end

			S_FREE_CHK: begin
				bit_sel = word_t'(1) << blk_q[BIT_IDX_W-1:0];
				wr_addr = blk_q[BLK_W-1:BIT_IDX_W];
				if ((word & bit_sel) == '0) begin
					st_d = ST_DOUBLE_FREE;
				end else begin
					wr_en   = 1'b1;
					wr_data = word & ~bit_sel;
				end
				state_d = S_DONE;
			end

			S_DONE: begin
				if (can_emit) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && can_emit) begin
			out_res_q <= res_q;
			out_st_q  <= st_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign block_number_res = out_res_q;
	assign status           = out_st_q;

endmodule
